// File: hdl/rpn_pkg.sv
// Shared sizes, token codes and status codes for the RPN stack evaluator.
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int TOP_W       = 32;
    localparam int NUM_W       = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = $clog2(DATA_W);

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_OP   = 2'd1,
        REQ_END  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_DIVZERO = 3'd2,
        ST_FULL    = 3'd3,
        ST_BADEND  = 3'd4
    } t_status;

endpackage

// File: hdl/rpn_stack_evaluator.sv
// Reverse Polish evaluator: operand stack memory plus one shared adder under a sequencer.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------------
//  token   | in        | i_in_valid / o_in_stall     | i_req_type, i_number, i_operator_code
//  result  | out       | o_out_valid / i_out_stall   | o_status, o_top_value, o_depth,
//          |           |                             | o_expression_done
//
// One token at a time: a token is taken only in the idle state, so the next one waits until the
// result of the last has transferred. Multiply and divide loop on the shared adder, stepping one
// bit per cycle. A divide by zero fetches the new top from the stack memory, unless it empties
// the stack. The next token transfers in the cycle after the result at the earliest; a stalled
// result holds and blocks the input until it goes.
// Reset (i_rst_n low, synchronous) stalls the input, empties the stack and clears the error.
module rpn_stack_evaluator
    import rpn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_req_type,
    input  logic signed [NUM_W-1:0] i_number,
    input  logic [1:0]              i_operator_code,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_status,
    output logic signed [TOP_W-1:0] o_top_value,
    output logic [SP_W-1:0]         o_depth,
    output logic                    o_expression_done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LDA,
        S_ADDSUB,
        S_MUL,
        S_ABSA,
        S_ABSB,
        S_DIV,
        S_SIGNQ,
        S_WB,
        S_RDTOP,
        S_TOPLD,
        S_REPORT,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [SP_W-1:0]     r_sp;
    t_status             r_err;
    logic [DATA_W-1:0]   r_top;
    t_op                 r_op;
    logic [DATA_W-1:0]   r_a;
    logic [DATA_W-1:0]   r_b;
    logic [DATA_W-1:0]   r_acc;
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_q;
    logic                r_neg;
    logic [CNT_W-1:0]    r_cnt;

    t_status             r_out_status;
    logic [TOP_W-1:0]    r_out_top;
    logic [SP_W-1:0]     r_out_depth;
    logic                r_out_done;

    logic [DATA_W-1:0]   r_stack [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rd_data;

    logic                in_xfer;
    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;
    logic [DATA_W-1:0]   num_ext;
    logic                stack_full;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;

    logic [DATA_W:0]     add_x;
    logic [DATA_W:0]     add_y;
    logic                add_sub;
    logic [DATA_W+1:0]   add_full;
    logic [DATA_W-1:0]   add_low;
    logic                add_carry;

    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign sp_m1      = r_sp - SP_W'(1);
    assign sp_m2      = r_sp - SP_W'(2);
    assign num_ext    = DATA_W'(i_number);
    assign stack_full = (r_sp >= SP_W'(STACK_DEPTH));

    assign o_in_stall        = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid       = (r_state == S_OUT);
    assign o_status          = r_out_status;
    assign o_top_value       = r_out_top;
    assign o_depth           = r_out_depth;
    assign o_expression_done = r_out_done;

    // Shared adder: add, subtract, multiply accumulate, negate and divide trial subtract.
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_ADDSUB: begin
                add_x   = {1'b0, r_a};
                add_y   = {1'b0, r_b};
                add_sub = (r_op == OP_SUB);
            end
            S_MUL: begin
                add_x = {1'b0, r_acc};
                add_y = {1'b0, r_a};
            end
            S_ABSA: begin
                add_y   = {1'b0, r_a};
                add_sub = 1'b1;
            end
            S_ABSB: begin
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            S_DIV: begin
                add_x   = {r_rem, r_q[DATA_W-1]};
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            S_SIGNQ: begin
                add_y   = {1'b0, r_q};
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_full  = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + (DATA_W + 2)'(add_sub);
    assign add_low   = add_full[DATA_W-1:0];
    assign add_carry = add_full[DATA_W+1];

    // Stack memory port: one write, one registered read.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sp[IDX_W-1:0];
        mem_wdata = num_ext;
        if (in_xfer && (t_req'(i_req_type) == REQ_PUSH) && (r_err == ST_OK) && !stack_full) begin
            mem_we = 1'b1;
        end else if (r_state == S_WB) begin
            mem_we    = 1'b1;
            mem_waddr = sp_m2[IDX_W-1:0];
            mem_wdata = r_acc;
        end
    end

    assign mem_raddr = (r_state == S_RDTOP) ? sp_m1[IDX_W-1:0] : sp_m2[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_stack[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_err   <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (t_req'(i_req_type))
                            REQ_END: begin
                                r_out_status <= r_err;
                                r_out_top    <= '0;
                                if (r_err == ST_OK) begin
                                    if (r_sp == SP_W'(1)) begin
                                        r_out_top <= TOP_W'(r_top);
                                    end else begin
                                        r_out_status <= ST_BADEND;
                                    end
                                end
                                r_out_depth <= '0;
                                r_out_done  <= 1'b1;
                                r_sp        <= '0;
                                r_err       <= ST_OK;
                                r_state     <= S_OUT;
                            end
                            REQ_PUSH: begin
                                if (r_err == ST_OK) begin
                                    if (stack_full) begin
                                        r_err <= ST_FULL;
                                    end else begin
                                        r_sp  <= r_sp + SP_W'(1);
                                        r_top <= num_ext;
                                    end
                                end
                                r_state <= S_REPORT;
                            end
                            REQ_OP: begin
                                if (r_err != ST_OK) begin
                                    r_state <= S_REPORT;
                                end else if (r_sp < SP_W'(2)) begin
                                    r_err   <= ST_UNDER;
                                    r_state <= S_REPORT;
                                end else begin
                                    // right operand is the cached top; left one is being read
                                    r_b     <= r_top;
                                    r_op    <= t_op'(i_operator_code);
                                    r_state <= S_LDA;
                                end
                            end
                            default: begin
                                r_state <= S_REPORT;
                            end
                        endcase
                    end
                end
                S_LDA: begin
                    r_a   <= r_rd_data;
                    r_neg <= r_rd_data[DATA_W-1] ^ r_b[DATA_W-1];
                    if ((r_op == OP_DIV) && (r_b == '0)) begin
                        r_err   <= ST_DIVZERO;
                        r_sp    <= sp_m2;
                        r_state <= (sp_m2 != '0) ? S_RDTOP : S_REPORT;
                    end else begin
                        unique case (r_op)
                            OP_ADD, OP_SUB: begin
                                r_state <= S_ADDSUB;
                            end
                            OP_MUL: begin
                                r_acc   <= '0;
                                r_cnt   <= CNT_W'(DATA_W - 1);
                                r_state <= S_MUL;
                            end
                            OP_DIV: begin
                                r_state <= S_ABSA;
                            end
                        endcase
                    end
                end
                S_ADDSUB: begin
                    r_acc   <= add_low;
                    r_state <= S_WB;
                end
                S_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= add_low;
                    end
                    r_a   <= {r_a[DATA_W-2:0], 1'b0};
                    r_b   <= {1'b0, r_b[DATA_W-1:1]};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_WB;
                    end
                end
                S_ABSA: begin
                    if (r_a[DATA_W-1]) begin
                        r_a <= add_low;
                    end
                    r_state <= S_ABSB;
                end
                S_ABSB: begin
                    if (r_b[DATA_W-1]) begin
                        r_b <= add_low;
                    end
                    r_rem   <= '0;
                    r_q     <= r_a;
                    r_cnt   <= CNT_W'(DATA_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring step: keep the difference when the trial does not borrow
                    if (add_carry) begin
                        r_rem <= add_low;
                    end else begin
                        r_rem <= {r_rem[DATA_W-2:0], r_q[DATA_W-1]};
                    end
                    r_q   <= {r_q[DATA_W-2:0], add_carry};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_SIGNQ;
                    end
                end
                S_SIGNQ: begin
                    r_acc   <= r_neg ? add_low : r_q;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_top   <= r_acc;
                    r_sp    <= sp_m1;
                    r_state <= S_REPORT;
                end
                S_RDTOP: begin
                    r_state <= S_TOPLD;
                end
                S_TOPLD: begin
                    r_top   <= r_rd_data;
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    r_out_status <= r_err;
                    r_out_top    <= (r_sp == '0) ? '0 : TOP_W'(r_top);
                    r_out_depth  <= r_sp;
                    r_out_done   <= 1'b0;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// File: test/tb_rpn_stack_evaluator.sv
// Self-checking testbench for the RPN stack evaluator: token stimulus, result prediction, checks.
module tb_rpn_stack_evaluator
    import rpn_pkg::*;
();

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]      status;
        logic [31:0]     top;
        logic [SP_W-1:0] depth;
        logic            done;
    } t_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [1:0]              i_req_type;
    logic signed [NUM_W-1:0] i_number;
    logic [1:0]              i_operator_code;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [2:0]              o_status;
    logic signed [TOP_W-1:0] o_top_value;
    logic [SP_W-1:0]         o_depth;
    logic                    o_expression_done;

    rpn_stack_evaluator uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_number          (i_number),
        .i_operator_code   (i_operator_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_top_value       (o_top_value),
        .o_depth           (o_depth),
        .o_expression_done (o_expression_done)
    );

    always #5 i_clk = ~i_clk;

    // Predicted block state
    logic [31:0] calc_stack [STACK_DEPTH];
    int          calc_sp;
    t_status     calc_err;

    t_result pending_results[$];
    int      error_count = 0;
    int      tokens_sent = 0;
    int      results_seen = 0;
    bit      sender_idle_en = 1'b1;
    bit      sink_idle_en = 1'b1;
    int      sink_hold_cycles = 0;

    function automatic logic [31:0] combine_operands(input logic [1:0] op,
                                                     input logic [31:0] lhs,
                                                     input logic [31:0] rhs);
        logic [31:0] mag_l;
        logic [31:0] mag_r;
        logic [31:0] quot;
        case (op)
            OP_ADD: return lhs + rhs;
            OP_SUB: return lhs - rhs;
            OP_MUL: return lhs * rhs;
            default: begin
                // truncate toward zero on magnitudes, then fix the sign
                mag_l = lhs[31] ? (~lhs + 32'd1) : lhs;
                mag_r = rhs[31] ? (~rhs + 32'd1) : rhs;
                quot  = mag_l / mag_r;
                return (lhs[31] ^ rhs[31]) ? (~quot + 32'd1) : quot;
            end
        endcase
    endfunction

    function automatic t_result evaluate_token(input logic [1:0] req,
                                               input logic [31:0] num,
                                               input logic [1:0] op);
        t_result     res;
        logic [31:0] lhs;
        logic [31:0] rhs;
        res = '0;
        if (req == REQ_END) begin
            res.status = calc_err;
            if (calc_err == ST_OK) begin
                if (calc_sp == 1) res.top = calc_stack[0];
                else res.status = ST_BADEND;
            end
            calc_sp  = 0;
            calc_err = ST_OK;
            res.done = 1'b1;
            return res;
        end
        if (calc_err == ST_OK) begin
            if (req == REQ_PUSH) begin
                if (calc_sp >= STACK_DEPTH) begin
                    calc_err = ST_FULL;
                end else begin
                    calc_stack[calc_sp] = num;
                    calc_sp++;
                end
            end else if (req == REQ_OP) begin
                if (calc_sp < 2) begin
                    calc_err = ST_UNDER;
                end else begin
                    rhs = calc_stack[calc_sp - 1];
                    lhs = calc_stack[calc_sp - 2];
                    calc_sp -= 2;
                    if (op == OP_DIV && rhs == 32'd0) begin
                        calc_err = ST_DIVZERO;
                    end else begin
                        calc_stack[calc_sp] = combine_operands(op, lhs, rhs);
                        calc_sp++;
                    end
                end
            end
        end
        res.status = calc_err;
        res.top    = (calc_sp == 0) ? 32'd0 : calc_stack[calc_sp - 1];
        res.depth  = calc_sp[SP_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Compare each transferred result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_seen, o_status, want.status));
                if (o_top_value !== want.top)
                    report_mismatch($sformatf("result %0d top %0d, want %0d",
                                              results_seen, o_top_value,
                                              $signed(want.top)));
                if (o_depth !== want.depth)
                    report_mismatch($sformatf("result %0d depth %0d, want %0d",
                                              results_seen, o_depth, want.depth));
                if (o_expression_done !== want.done)
                    report_mismatch($sformatf("result %0d done %0b, want %0b",
                                              results_seen, o_expression_done, want.done));
            end
        end
    end

    // Result side: random stall before each transfer, plus an optional long hold
    initial begin : result_sink
        int wait_cycles;
        i_out_stall <= 1'b0;
        forever begin
            if (sink_hold_cycles > 0) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (sink_hold_cycles - 1) @(negedge i_clk);
                sink_hold_cycles = 0;
            end
            wait_cycles = sink_idle_en ? $urandom_range(0, 18) : 0;
            if (wait_cycles > 0) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (wait_cycles - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_token(input logic [1:0] req, input logic [31:0] num,
                              input logic [1:0] op);
        int gap;
        gap = sender_idle_en ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_number        <= num;
        i_operator_code <= op;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(evaluate_token(req, num, op));
        tokens_sent++;
    endtask

    function automatic logic [31:0] draw_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom_range(0, 16) - 8;
            2: begin
                case ($urandom_range(0, 3))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return MINUS_ONE;
                    default: return 32'd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_value(input logic [31:0] num);
        send_token(REQ_PUSH, num, 2'($urandom));
    endtask

    task automatic apply_op(input t_op op);
        send_token(REQ_OP, $urandom, op);
    endtask

    task automatic end_expression();
        send_token(REQ_END, $urandom, 2'($urandom));
    endtask

    // Well-formed expression with random content; push_first stacks every operand first
    task automatic send_random_expression(input int n_operands, input bit push_first);
        int depth_v;
        int pushes_left;
        depth_v     = 0;
        pushes_left = n_operands;
        while (pushes_left > 0 || depth_v > 1) begin
            if (depth_v >= 2 &&
                (pushes_left == 0 || (!push_first && $urandom_range(0, 1) == 1))) begin
                apply_op(t_op'($urandom_range(0, 3)));
                depth_v--;
            end else begin
                push_value(draw_operand());
                pushes_left--;
                depth_v++;
            end
        end
        end_expression();
    endtask

    task automatic send_noise_sequence(input int n_tokens);
        repeat (n_tokens)
            send_token(2'($urandom_range(0, 3)), draw_operand(), 2'($urandom_range(0, 3)));
        end_expression();
    endtask

    task automatic wait_for_results();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        // add wrap, then most negative times most positive
        push_value(MOST_POS);
        push_value(32'd1);
        apply_op(OP_ADD);
        push_value(MOST_POS);
        apply_op(OP_MUL);
        end_expression();
        // most negative divided by minus one wraps
        push_value(MOST_NEG);
        push_value(MINUS_ONE);
        apply_op(OP_DIV);
        end_expression();
        // truncating divide of a negative, then subtract
        push_value(-32'sd7);
        push_value(32'd2);
        apply_op(OP_DIV);
        push_value(32'd3);
        apply_op(OP_SUB);
        end_expression();
        // too few operands, later push ignored while the error is pending
        push_value(32'd9);
        apply_op(OP_SUB);
        push_value(32'd1);
        end_expression();
        // divide by zero
        push_value(32'd5);
        push_value(32'd0);
        apply_op(OP_DIV);
        end_expression();
        // bad final depth: empty and two values
        end_expression();
        push_value(32'd1);
        push_value(32'd2);
        end_expression();
        // unused request type changes nothing
        send_token(REQ_UNUSED, $urandom, 2'($urandom));
        wait_for_results();
    endtask

    task automatic test_stack_full();
        repeat (STACK_DEPTH) push_value(draw_operand());
        push_value(draw_operand());
        apply_op(OP_ADD);
        end_expression();
        send_random_expression(STACK_DEPTH, 1'b1);
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        sender_idle_en   = 1'b0;
        sink_hold_cycles = 300;
        send_random_expression(6, 1'b0);
        send_random_expression(5, 1'b0);
        wait_for_results();
        sender_idle_en = 1'b1;
    endtask

    task automatic test_random_expressions();
        while (tokens_sent < 940) begin
            sender_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en   = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 2)
                send_noise_sequence($urandom_range(1, 10));
            else if ($urandom_range(0, 29) == 0)
                send_random_expression($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2), 1'b1);
            else
                send_random_expression($urandom_range(1, 8), 1'b0);
            if ($urandom_range(0, 9) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_req_type      <= REQ_PUSH;
        i_number        <= '0;
        i_operator_code <= OP_ADD;
        calc_sp  = 0;
        calc_err = ST_OK;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_directed_cases();
        test_stack_full();
        test_output_backpressure();
        test_random_expressions();

        // drain tail: catch any stray result
        repeat (60) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
